>>> rtl/gdow_pkg.sv
// Shared types, constants and the month offset table for the weekday unit.
package gdow_pkg;

  localparam int unsigned DayW   = 5;
  localparam int unsigned MonthW = 4;
  localparam int unsigned YearW  = 12;
  localparam int unsigned WdayW  = 3;
  localparam int unsigned DoyW   = 9;

  localparam logic [YearW-1:0] EpochYear = 12'd1900;
  localparam logic [8:0]       Epoch400  = 9'd300;
  localparam logic [6:0]       Last100   = 7'd99;
  localparam logic [8:0]       Last400   = 9'd399;

  // floor(y/100) == (y*Recip100) >> Shift100 for every 12-bit y
  localparam logic [10:0] Recip100 = 11'd1311;
  localparam int unsigned Shift100 = 17;
  // floor(x/7) == (x*Recip7) >> Shift7 for every x below 366
  localparam logic [8:0]  Recip7   = 9'd293;
  localparam int unsigned Shift7   = 11;

  typedef struct packed {
    logic load;
    logic calc_leap;
    logic latch_leap;
    logic step_year;
    logic calc_doy;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic ok;
    logic year_done;
  } status_t;

  function automatic logic [DoyW-1:0] days_before_month(input logic [MonthW-1:0] m);
    logic [DoyW-1:0] r;
    unique case (m)
      4'd1:    r = 9'd0;
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/gregorian_day_of_week.sv
// Top level of the Gregorian weekday, day-of-year and leap-year unit.
//
// Usage:
//   Drive day_i, month_i and year_i and raise start_i. The beat is taken at
//   the rising edge where start_i is high and busy_o is low; the fields are
//   latched there and may change afterwards.
//   The result beat appears on weekday_o, day_of_year_o, leap_year_o and
//   valid_res_o, marked by done_o high for exactly one cycle. The receiver
//   has no back-pressure: capture the result while done_o is high.
// Sequencing:
//   A date passing the range checks goes through the leap check, the year
//   walk from 1900 to its year, the day-of-year step and the result step;
//   the year walk adds one year per cycle.
//   A date failing the checks finishes from the check state, without the walk.
//   busy_o drops in the cycle done_o rises, so the next beat may be taken
//   at the edge that ends the result cycle. One date is in flight at a time.
// Reset:
//   rst_ni clears the sequencer and the result registers; no beat is emitted
//   by reset itself, and a date in flight is dropped.
module gregorian_day_of_week #(
  parameter int unsigned MAX_YEAR = 2399
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [gdow_pkg::DayW-1:0]     day_i,
  input  logic [gdow_pkg::MonthW-1:0]   month_i,
  input  logic [gdow_pkg::YearW-1:0]    year_i,
  output logic                          done_o,
  output logic [gdow_pkg::WdayW-1:0]    weekday_o,
  output logic [gdow_pkg::DoyW-1:0]     day_of_year_o,
  output logic                          leap_year_o,
  output logic                          valid_res_o
);

  gdow_pkg::cmd_t    cmd;
  gdow_pkg::status_t status;

  gdow_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy_o),
    .done_o   (done_o)
  );

  gdow_dp #(
    .MAX_YEAR (MAX_YEAR)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .day_i         (day_i),
    .month_i       (month_i),
    .year_i        (year_i),
    .weekday_o     (weekday_o),
    .day_of_year_o (day_of_year_o),
    .leap_year_o   (leap_year_o),
    .valid_res_o   (valid_res_o)
  );

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result beat while busy");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("accepted beat did not start work");

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy_o))
    else $error("result beat without work");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !valid_res_o) |-> (weekday_o == '0 && day_of_year_o == '0))
    else $error("invalid result not zeroed");

  a_valid_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && valid_res_o) |-> (weekday_o <= 3'd6 && day_of_year_o != '0 &&
                                 day_of_year_o <= 9'd366))
    else $error("valid result out of range");

endmodule

>>> rtl/gdow_ctrl.sv
// Sequencer that walks one date through leap check, year walk and weekday fold.
module gdow_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  gdow_pkg::status_t status_i,
  output gdow_pkg::cmd_t    cmd_o,
  output logic             busy_o,
  output logic             done_o
);

  typedef enum logic [2:0] {
    StIdle,
    StLeap,
    StCheck,
    StYears,
    StDoy,
    StFin
  } state_e;

  state_e state_q, state_d;
  logic   done_q, done_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    done_d  = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = StLeap;
        end
      end
      StLeap: begin
        cmd_o.calc_leap = 1'b1;
        state_d         = StCheck;
      end
      StCheck: begin
        cmd_o.latch_leap = 1'b1;
        if (status_i.ok) begin
          state_d = StYears;
        end else begin
          cmd_o.finish = 1'b1;
          done_d       = 1'b1;
          state_d      = StIdle;
        end
      end
      StYears: begin
        if (status_i.year_done) begin
          state_d = StDoy;
        end else begin
          cmd_o.step_year = 1'b1;
        end
      end
      StDoy: begin
        cmd_o.calc_doy = 1'b1;
        state_d        = StFin;
      end
      StFin: begin
        cmd_o.finish = 1'b1;
        done_d       = 1'b1;
        state_d      = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  assign busy_o = (state_q != StIdle);
  assign done_o = done_q;

endmodule

>>> rtl/gdow_dp.sv
// Datapath: input latch, leap rule, year walk accumulator and result registers.
module gdow_dp #(
  parameter int unsigned MAX_YEAR = 2399
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  gdow_pkg::cmd_t                cmd_i,
  output gdow_pkg::status_t             status_o,
  input  logic [gdow_pkg::DayW-1:0]     day_i,
  input  logic [gdow_pkg::MonthW-1:0]   month_i,
  input  logic [gdow_pkg::YearW-1:0]    year_i,
  output logic [gdow_pkg::WdayW-1:0]    weekday_o,
  output logic [gdow_pkg::DoyW-1:0]     day_of_year_o,
  output logic                          leap_year_o,
  output logic                          valid_res_o
);

  logic [gdow_pkg::DayW-1:0]   day_q;
  logic [gdow_pkg::MonthW-1:0] month_q;
  logic [gdow_pkg::YearW-1:0]  year_q;
  logic [5:0]                  q100_q;
  logic                        leap_q;
  logic [gdow_pkg::YearW-1:0]  cy_q;
  logic [1:0]                  c4_q;
  logic [6:0]                  c100_q;
  logic [8:0]                  c400_q;
  logic [2:0]                  wd_q;
  logic [gdow_pkg::DoyW-1:0]   doy_q;

  logic [gdow_pkg::WdayW-1:0]  weekday_q;
  logic [gdow_pkg::DoyW-1:0]   day_of_year_q;
  logic                        leap_year_q;
  logic                        valid_res_q;

  logic [22:0]                 prod100;
  logic [gdow_pkg::YearW-1:0]  back100;
  logic                        div100;
  logic                        leap_d;
  logic                        ok;
  logic                        cy_leap;
  logic [3:0]                  wd_add;
  logic [2:0]                  wd_step;
  logic [gdow_pkg::DoyW-1:0]   doy_d;
  logic [gdow_pkg::DoyW-1:0]   doy_m1;
  logic [17:0]                 prod7;
  logic [5:0]                  q7;
  logic [gdow_pkg::DoyW-1:0]   r7_full;
  logic [3:0]                  wd_sum;
  logic [2:0]                  wd_fin;

  assign prod100 = 23'(year_q) * 23'(gdow_pkg::Recip100);
  assign back100 = 12'({q100_q, 6'd0} + {1'b0, q100_q, 5'd0} + {4'd0, q100_q, 2'd0});
  assign div100  = (back100 == year_q);
  assign leap_d  = (div100 && (q100_q[1:0] == 2'd0)) || (!div100 && (year_q[1:0] == 2'd0));

  assign ok = (day_q != '0) && (month_q != '0) && (month_q <= 4'd12) &&
              (year_q >= gdow_pkg::EpochYear) && (year_q <= 12'(MAX_YEAR));

  assign cy_leap = (c400_q == '0) || ((c4_q == 2'd0) && (c100_q != '0));
  assign wd_add  = {1'b0, wd_q} + (cy_leap ? 4'd2 : 4'd1);
  assign wd_step = (wd_add >= 4'd7) ? 3'(wd_add - 4'd7) : wd_add[2:0];

  assign doy_d = gdow_pkg::days_before_month(month_q) + 9'(day_q) +
                 ((leap_q && (month_q > 4'd2)) ? 9'd1 : 9'd0);

  assign doy_m1  = doy_q - 9'd1;
  assign prod7   = 18'(doy_m1) * 18'(gdow_pkg::Recip7);
  assign q7      = prod7[gdow_pkg::Shift7 +: 6];
  assign r7_full = doy_m1 - ({3'd0, q7} * 9'd7);
  assign wd_sum  = {1'b0, wd_q} + {1'b0, r7_full[2:0]};
  assign wd_fin  = (wd_sum >= 4'd7) ? 3'(wd_sum - 4'd7) : wd_sum[2:0];

  assign status_o.ok        = ok;
  assign status_o.year_done = (cy_q == year_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      day_q   <= day_i;
      month_q <= month_i;
      year_q  <= year_i;
      cy_q    <= gdow_pkg::EpochYear;
      c4_q    <= 2'd0;
      c100_q  <= '0;
      c400_q  <= gdow_pkg::Epoch400;
      wd_q    <= '0;
    end
    if (cmd_i.calc_leap) begin
      q100_q <= prod100[gdow_pkg::Shift100 +: 6];
    end
    if (cmd_i.latch_leap) begin
      leap_q <= leap_d;
    end
    if (cmd_i.step_year) begin
      cy_q   <= cy_q + 12'd1;
      c4_q   <= c4_q + 2'd1;
      c100_q <= (c100_q == gdow_pkg::Last100) ? '0 : c100_q + 7'd1;
      c400_q <= (c400_q == gdow_pkg::Last400) ? '0 : c400_q + 9'd1;
      wd_q   <= wd_step;
    end
    if (cmd_i.calc_doy) begin
      doy_q <= doy_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weekday_q     <= '0;
      day_of_year_q <= '0;
      leap_year_q   <= 1'b0;
      valid_res_q   <= 1'b0;
    end else if (cmd_i.finish) begin
      if (cmd_i.latch_leap) begin
        weekday_q     <= '0;
        day_of_year_q <= '0;
        leap_year_q   <= leap_d;
        valid_res_q   <= 1'b0;
      end else begin
        weekday_q     <= wd_fin;
        day_of_year_q <= doy_q;
        leap_year_q   <= leap_q;
        valid_res_q   <= 1'b1;
      end
    end
  end

  assign weekday_o     = weekday_q;
  assign day_of_year_o = day_of_year_q;
  assign leap_year_o   = leap_year_q;
  assign valid_res_o   = valid_res_q;

endmodule
